// ----- design/bba_pkg.sv -----
package bba_pkg;

  // Default geometry of the bitmap
  localparam int MAP_BITS_DEF      = 4096;
  localparam int WORD_BITS_DEF     = 32;
  localparam int BLOCK_SECTORS_DEF = 2;

  // Fixed field widths
  localparam int CNT_W     = 13;
  localparam int SECT_W    = 32;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam int CNT_RESET = 4096;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SECTOR = 1'b1;

  // Request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN,
    OP_SET_FULL,
    OP_MUL,
    OP_ADDR,
    OP_RANGE,
    OP_SET_RANGE,
    OP_DIV_IDX,
    OP_DIV_WORD,
    OP_READ,
    OP_TEST,
    OP_EMIT
  } op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic func;
    logic limit_zero;
    logic range_bad;
    logic div_busy;
    logic scan_found;
    logic scan_full;
    logic clear_last;
  } sts_t;

endpackage

// ----- design/bba_ram.sv -----
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/bba_div.sv -----
module bba_div #(
  parameter int NUM_W = 15,
  parameter int DEN   = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  // Divide by a constant as a multiply by its rounded-up reciprocal. With a
  // shift of NUM_W + clog2(DEN) the quotient is exact for every num that fits
  // in NUM_W bits.
  localparam int SH = NUM_W + $clog2(DEN);
  localparam int RW = NUM_W + 1;
  localparam int PW = SH + NUM_W;
  localparam longint unsigned SCALE = 64'd1 << SH;
  localparam logic [RW-1:0] RECIP = RW'((SCALE + 64'(DEN) - 64'd1) / 64'(DEN));

  logic             pend;
  logic [NUM_W-1:0] num_q;
  logic [PW-1:0]    prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= start;
    end
  end

  // Latch the dividend, then multiply it in the following cycle
  always_ff @(posedge clk) begin
    if (start) begin
      num_q <= num;
    end
    if (pend) begin
      prod <= {{SH{1'b0}}, num_q} * {{(PW - RW){1'b0}}, RECIP};
    end
  end

  assign busy = pend;
  assign quot = prod[PW-1:SH];

endmodule

// ----- design/bba_dp.sv -----
module bba_dp #(
  parameter int MAP_BITS      = bba_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS     = bba_pkg::WORD_BITS_DEF,
  parameter int BLOCK_SECTORS = bba_pkg::BLOCK_SECTORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bba_pkg::SECT_W-1:0]     cfg_data,
  input  logic                           func,
  input  logic [bba_pkg::SECT_W-1:0]     sector,
  input  bba_pkg::op_t                   op,
  output bba_pkg::sts_t                  sts,
  output logic [bba_pkg::SECT_W-1:0]     block_sector,
  output logic [bba_pkg::STAT_W-1:0]     status
);

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LIM_W     = bba_pkg::CNT_W;
  localparam int SW        = bba_pkg::SECT_W;
  localparam int BSW       = $clog2(BLOCK_SECTORS + 1);
  localparam int NUM_W     = LIM_W + BSW;
  localparam logic [NUM_W-1:0] WB_N = NUM_W'(WORD_BITS);
  localparam logic [LIM_W-1:0] LIM_RST =
    LIM_W'((bba_pkg::CNT_RESET > MAP_BITS) ? MAP_BITS : bba_pkg::CNT_RESET);

  // Configuration
  logic [LIM_W-1:0]     limit;
  logic [SW-1:0]        base;
  logic [NUM_W-1:0]     lim_prod;

  // Request
  logic                 func_q;
  logic [SW-1:0]        sector_q;

  // Clearing sweep
  logic [AW-1:0]        clr_ptr;

  // Scan issue and check stages
  logic [AW-1:0]        iss_word;
  logic [LIM_W-1:0]     iss_left;
  logic [LIM_W-1:0]     iss_base;
  logic                 chk_v;
  logic [AW-1:0]        chk_word;
  logic [LIM_W-1:0]     chk_left;
  logic [LIM_W-1:0]     chk_base;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] hit_bit;
  logic [BW-1:0]        hit_pos;
  logic                 scan_hit;
  logic [LIM_W-1:0]     found_idx;
  logic [NUM_W-1:0]     prod;

  // Free path
  logic [SW:0]          diff_full;
  logic [NUM_W-1:0]     diff;
  logic                 range_bad;
  logic [AW-1:0]        free_word;
  logic [BW-1:0]        free_pos;
  logic [WORD_BITS-1:0] free_bit;
  logic                 bit_set;

  // Dividers: sector offset to block index, block index to word
  logic                 idx_start;
  logic                 idx_busy;
  logic [NUM_W-1:0]     idx_quot;
  logic                 word_start;
  logic                 word_busy;
  logic [NUM_W-1:0]     word_quot;

  // Result
  logic [SW-1:0]        pend_sector;
  bba_pkg::status_t     pend_status;

  // Bitmap memory
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bba_div #(
    .NUM_W (NUM_W),
    .DEN   (BLOCK_SECTORS)
  ) u_div_idx (
    .clk   (clk),
    .rst   (rst),
    .start (idx_start),
    .num   (diff),
    .busy  (idx_busy),
    .quot  (idx_quot)
  );

  bba_div #(
    .NUM_W (NUM_W),
    .DEN   (WORD_BITS)
  ) u_div_word (
    .clk   (clk),
    .rst   (rst),
    .start (word_start),
    .num   (idx_quot),
    .busy  (word_busy),
    .quot  (word_quot)
  );

  assign idx_start  = (op == bba_pkg::OP_DIV_IDX);
  assign word_start = (op == bba_pkg::OP_DIV_WORD);

  // Mask off bits at or beyond the block limit, then find the lowest free one
  always_comb begin
    valid_mask = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      valid_mask[i] = (LIM_W'(i) < chk_left);
    end
  end

  assign free_bits = ~ram_rdata & valid_mask;
  assign scan_hit  = |free_bits;

  always_comb begin
    hit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_pos = BW'(i);
      end
    end
  end

  assign hit_bit   = WORD_BITS'(1) << hit_pos;
  assign free_bit  = WORD_BITS'(1) << free_pos;
  assign bit_set   = ram_rdata[free_pos];
  assign diff_full = {1'b0, sector_q} - {1'b0, base};

  assign sts.func       = func_q;
  assign sts.limit_zero = (limit == '0);
  assign sts.range_bad  = range_bad;
  assign sts.div_busy   = idx_busy || word_busy;
  assign sts.scan_found = chk_v && scan_hit;
  assign sts.scan_full  = chk_v && !scan_hit && (chk_left <= LIM_W'(WORD_BITS));
  assign sts.clear_last = (clr_ptr == AW'(MAP_WORDS - 1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_ptr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = iss_word;
    case (op)
      bba_pkg::OP_CLEAR: begin
        ram_we = 1'b1;
      end
      bba_pkg::OP_SCAN: begin
        ram_re = (iss_left != '0);
        if (sts.scan_found) begin
          ram_we    = 1'b1;
          ram_waddr = chk_word;
          ram_wdata = ram_rdata | hit_bit;
        end
      end
      bba_pkg::OP_READ: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(word_quot);
      end
      bba_pkg::OP_TEST: begin
        ram_we    = bit_set;
        ram_waddr = free_word;
        ram_wdata = ram_rdata & ~free_bit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit   <= LIM_RST;
      base    <= '0;
      clr_ptr <= '0;
      chk_v   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          bba_pkg::CFG_BLOCK_COUNT: begin
            if (32'(cfg_data[LIM_W-1:0]) > 32'(MAP_BITS)) begin
              limit <= LIM_W'(MAP_BITS);
            end else begin
              limit <= cfg_data[LIM_W-1:0];
            end
          end
          bba_pkg::CFG_BASE_SECTOR: begin
            base <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (op == bba_pkg::OP_CLEAR) begin
        clr_ptr <= clr_ptr + AW'(1);
      end
      if (op == bba_pkg::OP_LOAD) begin
        chk_v <= 1'b0;
      end else if (op == bba_pkg::OP_SCAN) begin
        chk_v <= (iss_left != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_prod <= NUM_W'(limit * BLOCK_SECTORS);
    case (op)
      bba_pkg::OP_LOAD: begin
        func_q   <= func;
        sector_q <= sector;
        iss_word <= '0;
        iss_left <= limit;
        iss_base <= '0;
      end
      bba_pkg::OP_SCAN: begin
        chk_word <= iss_word;
        chk_left <= iss_left;
        chk_base <= iss_base;
        if (iss_left != '0) begin
          iss_word <= iss_word + AW'(1);
          iss_left <= (iss_left > LIM_W'(WORD_BITS)) ? iss_left - LIM_W'(WORD_BITS) : '0;
          iss_base <= iss_base + LIM_W'(WORD_BITS);
        end
        if (sts.scan_found) begin
          found_idx <= chk_base + LIM_W'(hit_pos);
        end
        if (sts.scan_full) begin
          pend_sector <= '0;
          pend_status <= bba_pkg::ST_FULL;
        end
      end
      bba_pkg::OP_SET_FULL: begin
        pend_sector <= '0;
        pend_status <= bba_pkg::ST_FULL;
      end
      bba_pkg::OP_MUL: begin
        prod <= NUM_W'(found_idx * BLOCK_SECTORS);
      end
      bba_pkg::OP_ADDR: begin
        pend_sector <= base + SW'(prod);
        pend_status <= bba_pkg::ST_OK;
      end
      bba_pkg::OP_RANGE: begin
        diff      <= diff_full[NUM_W-1:0];
        range_bad <= diff_full[SW] || (diff_full[SW-1:0] >= SW'(lim_prod));
      end
      bba_pkg::OP_SET_RANGE: begin
        pend_sector <= '0;
        pend_status <= bba_pkg::ST_RANGE;
      end
      bba_pkg::OP_READ: begin
        free_word <= AW'(word_quot);
        free_pos  <= BW'(idx_quot - word_quot * WB_N);
      end
      bba_pkg::OP_TEST: begin
        pend_sector <= '0;
        pend_status <= bit_set ? bba_pkg::ST_OK : bba_pkg::ST_NOT_ALLOC;
      end
      bba_pkg::OP_EMIT: begin
        block_sector <= pend_sector;
        status       <= pend_status;
      end
      default: begin
      end
    endcase
  end

  a_chk_in_limit: assert property (@(posedge clk) disable iff (rst)
    chk_v |-> (chk_left != '0))
    else $error("scan checked a word past the block limit");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("bitmap read and write hit the same word");

endmodule

// ----- design/bba_ctrl.sv -----
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::op_t  op
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_MUL,
    S_ADDR,
    S_RCHK,
    S_DIV1,
    S_DIV2,
    S_TEST,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op         = bba_pkg::OP_NONE;
    case (state)
      S_CLEAR: begin
        op = bba_pkg::OP_CLEAR;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op         = bba_pkg::OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.func)
          bba_pkg::FUNC_ALLOC: begin
            if (sts.limit_zero) begin
              op         = bba_pkg::OP_SET_FULL;
              state_next = S_DONE;
            end else begin
              state_next = S_SCAN;
            end
          end
          bba_pkg::FUNC_FREE: begin
            op         = bba_pkg::OP_RANGE;
            state_next = S_RCHK;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        op = bba_pkg::OP_SCAN;
        if (sts.scan_found) begin
          state_next = S_MUL;
        end else if (sts.scan_full) begin
          state_next = S_DONE;
        end
      end
      S_MUL: begin
        op         = bba_pkg::OP_MUL;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        op         = bba_pkg::OP_ADDR;
        state_next = S_DONE;
      end
      S_RCHK: begin
        if (sts.range_bad) begin
          op         = bba_pkg::OP_SET_RANGE;
          state_next = S_DONE;
        end else begin
          op         = bba_pkg::OP_DIV_IDX;
          state_next = S_DIV1;
        end
      end
      S_DIV1: begin
        if (!sts.div_busy) begin
          op         = bba_pkg::OP_DIV_WORD;
          state_next = S_DIV2;
        end
      end
      S_DIV2: begin
        if (!sts.div_busy) begin
          op         = bba_pkg::OP_READ;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        op         = bba_pkg::OP_TEST;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          op         = bba_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == bba_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_emit_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the done state");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted request was not dispatched");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("result overwritten before it was taken");

endmodule

// ----- design/bitmap_block_allocator_top.sv -----
// First-fit block allocator over a used/free bitmap kept in an on-chip RAM of
// MAP_BITS/WORD_BITS words. An allocate request (func 0) returns the sector of
// the lowest free block below block_count and marks it used; a free request
// (func 1) turns a sector back into a block index and clears its bit. After
// reset the block runs a clearing pass over every RAM word (128 by default)
// and holds in_ready low; configuration writes are taken at all times but
// must only be issued while no request is in flight. Each request is handled
// on its own. An allocate is paced by the bitmap scan, which reads one RAM
// word per cycle; a free whose sector is in range runs two constant divisions
// done as reciprocal multiplies, the first finding the block index and the
// second splitting it into word and bit. A finished result sits in the output
// register while the next request is accepted.
module bitmap_block_allocator_top #(
  parameter int MAP_BITS      = bba_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS     = bba_pkg::WORD_BITS_DEF,
  parameter int BLOCK_SECTORS = bba_pkg::BLOCK_SECTORS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::SECT_W-1:0]    cfg_data,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [bba_pkg::SECT_W-1:0]    sector,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bba_pkg::SECT_W-1:0]    block_sector,
  output logic [bba_pkg::STAT_W-1:0]    status
);

  bba_pkg::op_t  op;
  bba_pkg::sts_t sts;

  // Register writes are always taken, so the channel never stalls
  assign cfg_ready = 1'b1;

  // Sequencer: clearing sweep, request dispatch, scan and divide steps,
  // and the handoff into the output register
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .op        (op)
  );

  // Bitmap RAM, config registers, scan pipeline, dividers and result registers
  bba_dp #(
    .MAP_BITS      (MAP_BITS),
    .WORD_BITS     (WORD_BITS),
    .BLOCK_SECTORS (BLOCK_SECTORS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .sector       (sector),
    .op           (op),
    .sts          (sts),
    .block_sector (block_sector),
    .status       (status)
  );

endmodule

// ----- tb/bitmap_block_allocator_top_tb.sv -----
`timescale 1ns / 1ps

module bitmap_block_allocator_top_tb;
  import bba_pkg::*;

  localparam int MAP_BITS    = MAP_BITS_DEF;
  localparam int BLK_SECTORS = BLOCK_SECTORS_DEF;

  // Kinds of entries in the sender's command queue
  typedef enum logic [1:0] {
    CMD_REQ,    // one allocate or free request
    CMD_CFG,    // one register write, issued only once nothing is in flight
    CMD_PAUSE   // hold the sender until every awaited reply is back
  } cmd_kind_t;

  typedef struct {
    cmd_kind_t               kind;
    logic                    fn;
    logic [SECT_W-1:0]       addr;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [SECT_W-1:0]       reg_val;
    int unsigned             gap;     // idle cycles after this request
    bit                      quiet;   // no idling on either side
  } alloc_cmd_t;

  typedef struct packed {
    logic [SECT_W-1:0] sect;
    status_t           code;
  } alloc_reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SECT_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 func = FUNC_ALLOC;
  logic [SECT_W-1:0]    sector = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SECT_W-1:0]    block_sector;
  logic [STAT_W-1:0]    status;

  bitmap_block_allocator_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .sector       (sector),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .block_sector (block_sector),
    .status       (status)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the allocator: used bitmap and the two registers
  bit               block_used [MAP_BITS];
  logic [CNT_W-1:0] blk_count = CNT_W'(CNT_RESET);
  logic [SECT_W-1:0] base_reg = '0;

  alloc_cmd_t   pending_cmds[$];
  alloc_reply_t awaited_replies[$];

  int          accepted_cnt = 0;   // requests taken by the block
  int          retired_cnt = 0;    // replies taken from the block
  int          mismatch_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned rx_stall = 0;
  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;
  bit          gen_done = 1'b0;
  bit          bench_drained = 1'b0;
  bit          gen_quiet = 1'b0;

  // Work out the reply to one request and advance the shadow bitmap.
  // Allocate is first fit below the usable limit; free maps a sector back
  // to its block, truncating any offset inside the block.
  function automatic void predict_reply(input logic fn, input logic [SECT_W-1:0] addr);
    alloc_reply_t      r;
    int unsigned       lim;
    logic [SECT_W-1:0] idx;
    // A count beyond the map is clamped to the map size
    lim = (blk_count > MAP_BITS) ? MAP_BITS : blk_count;
    r.sect = '0;
    r.code = ST_FULL;
    if (fn == FUNC_ALLOC) begin
      for (int unsigned i = 0; i < lim; i++) begin
        if (!block_used[i]) begin
          block_used[i] = 1'b1;
          // wraps modulo 2^32 near the top of the sector space
          r.sect = base_reg + SECT_W'(i) * SECT_W'(BLK_SECTORS);
          r.code = ST_OK;
          break;
        end
      end
    end else if (addr < base_reg) begin
      r.code = ST_RANGE;
    end else begin
      idx = (addr - base_reg) / SECT_W'(BLK_SECTORS);
      if (idx >= lim) begin
        r.code = ST_RANGE;
      end else if (!block_used[idx]) begin
        r.code = ST_NOT_ALLOC;     // double free or never allocated
      end else begin
        block_used[idx] = 1'b0;
        r.code = ST_OK;
      end
    end
    awaited_replies.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input alloc_reply_t want,
                                 input logic [SECT_W-1:0] got_sect,
                                 input logic [STAT_W-1:0] got_code);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s: expected sector %h status %0d, got sector %h status %0d",
               $time, what, want.sect, want.code, got_sect, got_code);
  endtask

  // Queue one request; the idle gap after it is drawn here
  task automatic push_req(input logic fn, input logic [SECT_W-1:0] addr);
    alloc_cmd_t c;
    c = '{kind: CMD_REQ, fn: fn, addr: addr, reg_idx: '0, reg_val: '0,
          gap: 0, quiet: gen_quiet};
    if (!gen_quiet && $urandom_range(0, 2) == 0)
      c.gap = $urandom_range(1, 10);
    pending_cmds.push_back(c);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SECT_W-1:0] val);
    pending_cmds.push_back('{kind: CMD_CFG, fn: FUNC_ALLOC, addr: '0, reg_idx: idx,
                             reg_val: val, gap: 0, quiet: gen_quiet});
  endtask

  // Build the whole command stream up front, then release reset.
  initial begin
    int unsigned       phase;
    int unsigned       total;
    int unsigned       n;
    int unsigned       lim;
    int unsigned       hi;
    int unsigned       used_guess;
    int unsigned       roll;
    logic [SECT_W-1:0] base;
    logic [SECT_W-1:0] cnt;

    // Directed part, reset settings: count 4096, base 0
    push_req(FUNC_ALLOC, 32'hFFFF_FFFF);
    push_req(FUNC_ALLOC, 32'h0000_0000);
    push_req(FUNC_FREE, 32'd3);            // misaligned, names block 1
    push_req(FUNC_FREE, 32'd3);            // same block again: not allocated
    push_req(FUNC_FREE, 32'hFFFF_FFFF);    // far out of range
    push_req(FUNC_FREE, 32'd8192);         // first index past the map
    // No usable block at all
    push_cfg(CFG_BLOCK_COUNT, 32'd0);
    push_req(FUNC_ALLOC, 32'h0);
    push_req(FUNC_FREE, 32'h0);
    // Tiny partition at the top of the sector space: wrap and fill up
    push_cfg(CFG_BLOCK_COUNT, 32'd3);
    push_cfg(CFG_BASE_SECTOR, 32'hFFFF_FFFF);
    push_req(FUNC_ALLOC, 32'h0);
    push_req(FUNC_ALLOC, 32'h0);
    push_req(FUNC_ALLOC, 32'h0);           // map full
    push_req(FUNC_FREE, 32'd5);            // below base
    push_req(FUNC_FREE, 32'hFFFF_FFFF);
    push_req(FUNC_ALLOC, 32'h0);
    // Count above the map size, base off zero
    push_cfg(CFG_BLOCK_COUNT, 32'd8191);
    push_cfg(CFG_BASE_SECTOR, 32'd100);
    push_req(FUNC_FREE, 32'd100 + 32'(2 * 4095) + 32'd1);
    push_req(FUNC_FREE, 32'd100 + 32'(2 * 4096));
    push_req(FUNC_ALLOC, 32'h0);
    push_req(FUNC_FREE, 32'd0);
    push_req(FUNC_FREE, 32'd101);

    // Random phases, each with its own count and base. Frees mostly aim at
    // blocks that are likely to be in use; the rest is raw noise.
    total = 0;
    phase = 0;
    used_guess = 4;
    while (total < 700) begin
      case (phase % 7)
        0:       cnt = $urandom_range(1, 64);
        1:       cnt = 32'd4096;
        2:       cnt = 32'd1;
        3:       cnt = 32'd8191;
        4:       cnt = $urandom_range(0, 8191);
        5:       cnt = 32'd0;
        default: cnt = $urandom_range(2, 300);
      endcase
      case (phase % 4)
        0:       base = 32'h0;
        1:       base = $urandom;
        2:       base = 32'hFFFF_FFFF - $urandom_range(0, 64);
        default: base = $urandom_range(0, 1000);
      endcase
      lim = (cnt > MAP_BITS) ? MAP_BITS : cnt;
      n = (cnt == 0) ? 10 : $urandom_range(40, 90);
      // One idle-free stretch mid run, and none at all near the end
      gen_quiet = (phase == 3) || (total + n >= 620);
      push_cfg(CFG_BLOCK_COUNT, cnt);
      push_cfg(CFG_BASE_SECTOR, base);
      for (int unsigned k = 0; k < n; k++) begin
        if (k == n / 2 && phase % 3 == 1)
          pending_cmds.push_back('{kind: CMD_PAUSE, fn: FUNC_ALLOC, addr: '0,
                                   reg_idx: '0, reg_val: '0, gap: 0, quiet: gen_quiet});
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          push_req(FUNC_ALLOC, $urandom);
          used_guess++;
        end else if (roll < 90 && lim > 0) begin
          hi = (used_guess < lim) ? used_guess : lim;
          push_req(FUNC_FREE, base + SECT_W'($urandom_range(0, hi) * BLK_SECTORS)
                              + SECT_W'($urandom_range(0, BLK_SECTORS - 1)));
          if (used_guess > 1)
            used_guess--;
        end else begin
          push_req(FUNC_FREE, $urandom);
        end
      end
      total += n;
      phase++;
    end
    gen_done = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: present requests and register writes from the command queue
  always @(posedge clk) begin
    alloc_cmd_t head;
    logic       nv_in;
    logic       nv_cfg;
    int         in_flight;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      send_gap = 0;
    end else begin
      nv_in = in_valid;
      nv_cfg = cfg_valid;
      in_flight = accepted_cnt - retired_cnt;
      if (in_valid && in_ready) begin
        predict_reply(func, sector);
        accepted_cnt <= accepted_cnt + 1;
        in_flight++;
        nv_in = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCK_COUNT: blk_count = cfg_data[CNT_W-1:0];
          default:         base_reg = cfg_data;
        endcase
        nv_cfg = 1'b0;
      end
      // Pick the next command only when both channels are free
      if (!nv_in && !nv_cfg && pending_cmds.size() != 0) begin
        if (send_gap != 0) begin
          send_gap--;
        end else begin
          head = pending_cmds[0];
          case (head.kind)
            CMD_REQ: begin
              void'(pending_cmds.pop_front());
              nv_in = 1'b1;
              func <= head.fn;
              sector <= head.addr;
              send_gap = head.gap;
              quiet <= head.quiet;
            end
            CMD_CFG: begin
              // Write registers only with nothing in flight
              if (in_flight == 0) begin
                void'(pending_cmds.pop_front());
                nv_cfg = 1'b1;
                cfg_index <= head.reg_idx;
                cfg_data <= head.reg_val;
              end
            end
            default: begin
              if (in_flight == 0)
                void'(pending_cmds.pop_front());
            end
          endcase
        end
      end
      in_valid <= nv_in;
      cfg_valid <= nv_cfg;
      bench_drained <= gen_done && pending_cmds.size() == 0 && !nv_in && !nv_cfg;
    end
  end

  // Receiver: check each reply against the oldest awaited one, stall at random
  always @(posedge clk) begin
    alloc_reply_t want;
    logic         nxt_ready;
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        retired_cnt <= retired_cnt + 1;
        if (awaited_replies.size() == 0) begin
          report_mismatch("reply with nothing awaited", '0, block_sector, status);
        end else begin
          want = awaited_replies.pop_front();
          if (block_sector !== want.sect || status !== want.code)
            report_mismatch("reply mismatch", want, block_sector, status);
        end
      end
      if (long_hold) begin
        nxt_ready = 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        nxt_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rx_stall = $urandom_range(1, 10) - 1;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // Hold off the receiver for a long stretch so the block backs up and
  // drops in_ready while requests keep coming.
  initial begin
    while (accepted_cnt < 60) @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  // End of run: wait for the last reply, keep waiting for anything stray, then
  // flag leftovers.
  initial begin
    while (!(bench_drained && accepted_cnt == retired_cnt)) @(posedge clk);
    repeat (300) @(posedge clk);
    while (awaited_replies.size() != 0)
      report_mismatch("reply never came", awaited_replies.pop_front(), 'x, 'x);
    if (mismatch_cnt == 0) begin
      $display("bitmap_block_allocator_top_tb: PASS");
    end else begin
      $display("bitmap_block_allocator_top_tb: FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("bitmap_block_allocator_top_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
design/bba_pkg.sv
design/bba_ram.sv
design/bba_div.sv
design/bba_dp.sv
design/bba_ctrl.sv
design/bitmap_block_allocator_top.sv
tb/bitmap_block_allocator_top_tb.sv
